>>> rtl/core/wbap_pkg.sv
package wbap_pkg;

   // field and register widths
   localparam int CfgW    = 4;
   localparam int PixW    = 8;
   localparam int PosW    = 4;
   localparam int MeanW   = 16;
   localparam int AreaW   = 8;
   localparam int CsrIdxW = 2;

   // accumulators keep the bits that survive the shift into the q8.8 dividend
   localparam int DivW = 32;
   localparam int SumW = DivW - 8;

   // divider: quotient bits retired per cycle and the resulting cycle count
   localparam int QBitsPerStep = 2;
   localparam int DivSteps     = DivW / QBitsPerStep;
   localparam int StepCntW     = $clog2(DivSteps);

   // accept of the ending pixel to result valid
   localparam int LatencyCycles = DivSteps + 2;

   // size bounds
   localparam int MAX_KERNEL_SIZE     = 15;
   localparam int DEFAULT_MAX_KERNELS = 15;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_KERNEL_SIZE = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_NUM_KERNELS = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_COLOR_MODE  = 2'd2;

   // register reset values
   localparam logic [CfgW-1:0] KERNEL_SIZE_RESET = 4'd3;
   localparam logic [CfgW-1:0] NUM_KERNELS_RESET = 4'd3;
   localparam logic            COLOR_MODE_RESET  = 1'b1;

   // control from the sequencer to every lane
   typedef struct packed {
      logic             accept;
      logic             start;
      logic             step;
      logic [AreaW-1:0] area;
   } lane_ctl_type;

   // position and mode of the kernel under division
   typedef struct packed {
      logic [PosW-1:0] kernel_row;
      logic [PosW-1:0] kernel_col;
      logic            window_done;
      logic            three;
   } job_type;

   // zero acts as one, values above the bound act as the bound
   function automatic logic [CfgW-1:0] clamp_count(input logic [CfgW-1:0] v, input int hi);
      logic [CfgW-1:0] r;
      r = v;
      if (v == '0) begin
         r = CfgW'(1);
      end else if (int'(v) > hi) begin
         r = CfgW'(hi);
      end
      return r;
   endfunction

endpackage

>>> rtl/core/wbap_req_if.sv
interface wbap_req_if;
   logic                         valid;
   logic                         ready;
   logic [wbap_pkg::PixW-1:0]    channel_0;
   logic [wbap_pkg::PixW-1:0]    channel_1;
   logic [wbap_pkg::PixW-1:0]    channel_2;

   modport source (output valid, output channel_0, output channel_1, output channel_2,
                   input ready);
   modport sink   (input valid, input channel_0, input channel_1, input channel_2,
                   output ready);
endinterface

>>> rtl/core/wbap_rsp_if.sv
interface wbap_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wbap_pkg::PosW-1:0]    kernel_row;
   logic [wbap_pkg::PosW-1:0]    kernel_col;
   logic [wbap_pkg::MeanW-1:0]   mean_0;
   logic [wbap_pkg::MeanW-1:0]   mean_1;
   logic [wbap_pkg::MeanW-1:0]   mean_2;
   logic                         window_done;

   modport source (output valid, output kernel_row, output kernel_col, output mean_0,
                   output mean_1, output mean_2, output window_done, input ready);
   modport sink   (input valid, input kernel_row, input kernel_col, input mean_0,
                   input mean_1, input mean_2, input window_done, output ready);
endinterface

>>> rtl/core/wbap_csr_if.sv
interface wbap_csr_if;
   logic                          valid;
   logic                          ready;
   logic [wbap_pkg::CsrIdxW-1:0]  index;
   logic [wbap_pkg::CfgW-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/window_block_average_pool.sv
// Block average pooling over a square window streamed in raster order.
// req_ch carries one pixel per transaction (channel_0..channel_2, 8 bits each);
// rsp_ch carries one finished kernel per transaction: its position, the three
// q8.8 means (floor of sum*256 / kernel_size^2) and the window_done flag.
// csr_ch writes kernel_size, num_kernels and color_mode; it is always ready and
// should only be written while no kernel result is outstanding.
// A pixel that does not end a kernel is never held off, so such pixels
// stream at one per cycle. A pixel that ends a kernel starts the shared
// three-lane divider, which retires two quotient bits a cycle; rsp_ch.valid
// rises once the divider has finished and its result is loaded into the
// output register. During the divide, pixels that do not end a kernel are
// still taken; the next kernel end waits until the divider has handed its
// result to the output register.
// With kernel_size 1 every pixel ends a kernel and waits for the previous hand-off.
// If rsp_ch stalls, the result waits in the output register and a further
// result waits in the divider, while pixels that do not end a kernel keep flowing.
// Reset clears all counters and accumulators, restores the register defaults
// (kernel_size 3, num_kernels 3, three channels) and drops rsp_ch.valid.
module window_block_average_pool #(
   parameter int MAX_KERNELS = wbap_pkg::DEFAULT_MAX_KERNELS
) (
   input  logic       clock,
   input  logic       reset,
   wbap_req_if.sink   req_ch,
   wbap_rsp_if.source rsp_ch,
   wbap_csr_if.sink   csr_ch
);
   import wbap_pkg::*;

   localparam int IdxW = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;

   lane_ctl_type     lane_ctl;
   job_type          job;
   logic [IdxW-1:0]  kc;
   logic             three, load, slot_free;
   logic [PixW-1:0]  sample [3];
   logic [MeanW-1:0] quot [3];

   assign sample[0] = req_ch.channel_0;
   assign sample[1] = req_ch.channel_1;
   assign sample[2] = req_ch.channel_2;

   wbap_ctrl #(
      .MAX_KERNELS (MAX_KERNELS),
      .IdxW        (IdxW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .slot_free (slot_free),
      .lane_ctl  (lane_ctl),
      .kc        (kc),
      .three     (three),
      .job       (job),
      .load      (load)
   );

   // one lane per color channel; the first is always in use
   for (genvar g = 0; g < 3; g++) begin : g_lane
      wbap_lane #(
         .MAX_KERNELS (MAX_KERNELS),
         .IdxW        (IdxW)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .lane_ctl (lane_ctl),
         .kc       (kc),
         .sample   (sample[g]),
         .use_lane ((g == 0) || three),
         .quotient (quot[g])
      );
   end

   wbap_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .job       (job),
      .q0        (quot[0]),
      .q1        (quot[1]),
      .q2        (quot[2]),
      .slot_free (slot_free),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> rtl/core/wbap_ctrl.sv
module wbap_ctrl #(
   parameter int MAX_KERNELS = wbap_pkg::DEFAULT_MAX_KERNELS,
   parameter int IdxW        = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   wbap_req_if.sink               req_ch,
   wbap_csr_if.sink               csr_ch,
   input  logic                   slot_free,
   output wbap_pkg::lane_ctl_type lane_ctl,
   output logic [IdxW-1:0]        kc,
   output logic                   three,
   output wbap_pkg::job_type      job,
   output logic                   load
);
   import wbap_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   logic [CfgW-1:0]     ks_ff, ks_in, nk_ff, nk_in;
   logic                cm_ff, cm_in;
   logic [PosW-1:0]     col_ff, col_in, row_ff, row_in, band_ff, band_in, kcol_ff, kcol_in;
   state_type           state_ff, state_in;
   logic [StepCntW-1:0] cnt_ff, cnt_in;
   job_type             job_ff, job_in;

   logic [CfgW-1:0] ks, nk;
   logic            last_col, last_row, last_kcol, last_band, kernel_end;
   logic            ready, accept, start;
   logic [4:0]      kc_wide;

   // effective sizes and end-of-run flags
   always_comb begin
      ks         = clamp_count(ks_ff, MAX_KERNEL_SIZE);
      nk         = clamp_count(nk_ff, MAX_KERNELS);
      last_col   = ({1'b0, col_ff} + 5'd1) >= {1'b0, ks};
      last_row   = ({1'b0, row_ff} + 5'd1) >= {1'b0, ks};
      last_kcol  = ({1'b0, kcol_ff} + 5'd1) >= {1'b0, nk};
      last_band  = ({1'b0, band_ff} + 5'd1) >= {1'b0, nk};
      kernel_end = last_col && last_row;
   end

   // accumulator select, held inside the bank
   always_comb begin
      kc_wide = ({1'b0, kcol_ff} >= 5'(MAX_KERNELS - 1)) ? 5'(MAX_KERNELS - 1)
                                                          : {1'b0, kcol_ff};
      kc = kc_wide[IdxW-1:0];
   end

   // a kernel-ending pixel needs the divider free
   always_comb begin
      ready  = (state_ff == ST_IDLE) || !kernel_end;
      accept = req_ch.valid && ready;
      start  = accept && kernel_end;
   end

   assign req_ch.ready = ready;
   assign csr_ch.ready = 1'b1;

   // configuration registers
   always_comb begin
      ks_in = ks_ff;
      nk_in = nk_ff;
      cm_in = cm_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_KERNEL_SIZE: ks_in = csr_ch.data;
            CSR_NUM_KERNELS: nk_in = csr_ch.data;
            CSR_COLOR_MODE:  cm_in = csr_ch.data[0];
            default:         ;
         endcase
      end
   end

   // raster position counters
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      band_in = band_ff;
      kcol_in = kcol_ff;
      if (accept) begin
         if (!last_col) begin
            col_in = col_ff + 4'd1;
         end else begin
            col_in = '0;
            if (!last_kcol) begin
               kcol_in = kcol_ff + 4'd1;
            end else begin
               kcol_in = '0;
               if (!last_row) begin
                  row_in = row_ff + 4'd1;
               end else begin
                  row_in  = '0;
                  band_in = last_band ? '0 : band_ff + 4'd1;
               end
            end
         end
      end
   end

   // divide sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      job_in   = job_ff;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in           = ST_DIV;
               cnt_in             = StepCntW'(DivSteps - 1);
               job_in.kernel_row  = band_ff;
               job_in.kernel_col  = kcol_ff;
               job_in.window_done = last_kcol && last_band;
               job_in.three       = cm_ff;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_HOLD;
            end else begin
               cnt_in = cnt_ff - StepCntW'(1);
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lane_ctl.accept = accept;
      lane_ctl.start  = start;
      lane_ctl.step   = (state_ff == ST_DIV);
      lane_ctl.area   = AreaW'({4'd0, ks} * {4'd0, ks});
      three           = cm_ff;
      job             = job_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ks_ff    <= KERNEL_SIZE_RESET;
         nk_ff    <= NUM_KERNELS_RESET;
         cm_ff    <= COLOR_MODE_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
         band_ff  <= '0;
         kcol_ff  <= '0;
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         ks_ff    <= ks_in;
         nk_ff    <= nk_in;
         cm_ff    <= cm_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         band_ff  <= band_in;
         kcol_ff  <= kcol_in;
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      job_ff <= job_in;
   end

endmodule

>>> rtl/core/wbap_lane.sv
module wbap_lane #(
   parameter int MAX_KERNELS = wbap_pkg::DEFAULT_MAX_KERNELS,
   parameter int IdxW        = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wbap_pkg::lane_ctl_type        lane_ctl,
   input  logic [IdxW-1:0]               kc,
   input  logic [wbap_pkg::PixW-1:0]     sample,
   input  logic                          use_lane,
   output logic [wbap_pkg::MeanW-1:0]    quotient
);
   import wbap_pkg::*;

   logic [SumW-1:0]  sum_ff [MAX_KERNELS];
   logic [SumW-1:0]  sum_in [MAX_KERNELS];
   logic [AreaW-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DivW-1:0]  dvd_ff, dvd_in;

   logic [SumW-1:0]  add;
   logic [AreaW-1:0] rem_v;
   logic [DivW-1:0]  dvd_v;
   logic [AreaW:0]   trial;
   logic             qbit;

   // accumulate into the current kernel column, clear it when the kernel ends
   always_comb begin
      add    = sum_ff[kc] + (use_lane ? SumW'(sample) : '0);
      sum_in = sum_ff;
      if (lane_ctl.accept) begin
         sum_in[kc] = lane_ctl.start ? '0 : add;
      end
   end

   // restoring divide of sum*256 by the kernel area, QBitsPerStep quotient bits per cycle
   always_comb begin
      rem_v = rem_ff;
      dvd_v = dvd_ff;
      trial = '0;
      qbit  = 1'b0;
      for (int i = 0; i < QBitsPerStep; i++) begin
         trial = {rem_v, dvd_v[DivW-1]};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_v = AreaW'(trial - {1'b0, dsr_ff});
            qbit  = 1'b1;
         end else begin
            rem_v = trial[AreaW-1:0];
            qbit  = 1'b0;
         end
         dvd_v = {dvd_v[DivW-2:0], qbit};
      end
   end

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      if (lane_ctl.start) begin
         rem_in = '0;
         dvd_in = {add, 8'h00};
         dsr_in = lane_ctl.area;
      end else if (lane_ctl.step) begin
         rem_in = rem_v;
         dvd_in = dvd_v;
      end
   end

   assign quotient = dvd_ff[MeanW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_KERNELS; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         sum_ff <= sum_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

endmodule

>>> rtl/core/wbap_merge.sv
module wbap_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  wbap_pkg::job_type             job,
   input  logic [wbap_pkg::MeanW-1:0]    q0,
   input  logic [wbap_pkg::MeanW-1:0]    q1,
   input  logic [wbap_pkg::MeanW-1:0]    q2,
   output logic                          slot_free,
   wbap_rsp_if.source                    rsp_ch
);
   import wbap_pkg::*;

   logic             valid_ff, valid_in;
   logic [PosW-1:0]  row_ff, row_in, col_ff, col_in;
   logic [MeanW-1:0] m0_ff, m0_in, m1_ff, m1_in, m2_ff, m2_in;
   logic             done_ff, done_in;

   assign slot_free = !valid_ff || rsp_ch.ready;

   // combine the lane quotients with the kernel position into one result
   always_comb begin
      valid_in = valid_ff && !rsp_ch.ready;
      row_in   = row_ff;
      col_in   = col_ff;
      m0_in    = m0_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      done_in  = done_ff;
      if (load) begin
         valid_in = 1'b1;
         row_in   = job.kernel_row;
         col_in   = job.kernel_col;
         m0_in    = q0;
         m1_in    = job.three ? q1 : '0;
         m2_in    = job.three ? q2 : '0;
         done_in  = job.window_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      row_ff  <= row_in;
      col_ff  <= col_in;
      m0_ff   <= m0_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      done_ff <= done_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.kernel_row  = row_ff;
   assign rsp_ch.kernel_col  = col_ff;
   assign rsp_ch.mean_0      = m0_ff;
   assign rsp_ch.mean_1      = m1_ff;
   assign rsp_ch.mean_2      = m2_ff;
   assign rsp_ch.window_done = done_ff;

endmodule

>>> rtl/core/wbap_checker.sv
module wbap_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [wbap_pkg::PosW-1:0]     kernel_row,
   input logic [wbap_pkg::PosW-1:0]     kernel_col,
   input logic [wbap_pkg::MeanW-1:0]    mean_0,
   input logic                          window_done
);
   import wbap_pkg::*;

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result must follow an accepted transaction at the divide latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, LatencyCycles))
      else $error("result without a kernel-ending transaction at the divide latency");

   // a stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its position, mean_0 and window_done
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(kernel_row) && $stable(kernel_col)
                                  && $stable(mean_0) && $stable(window_done))
      else $error("result payload changed while stalled");

endmodule

bind window_block_average_pool wbap_checker u_wbap_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .kernel_row  (rsp_ch.kernel_row),
   .kernel_col  (rsp_ch.kernel_col),
   .mean_0      (rsp_ch.mean_0),
   .window_done (rsp_ch.window_done)
);

>>> dv/window_block_average_pool_tb.sv
module window_block_average_pool_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wbap_pkg::*;

   localparam int SideBound      = 15;     // largest kernel side and kernel count
   localparam int RandomItems    = 850;
   localparam int QuietTailItems = 120;
   localparam int IdleMax        = 17;
   localparam int RspHoldCycles  = 400;
   localparam int HoldPhase      = 2;
   localparam int HoldBurstItems = 40;
   localparam int CycleLimit     = 500000;
   localparam int MaxReports     = 10;

   // index with no register behind it, writes to it are dropped
   localparam logic [CsrIdxW-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [PixW-1:0] ch0;
      logic [PixW-1:0] ch1;
      logic [PixW-1:0] ch2;
   } pixel_type;

   typedef struct packed {
      logic [PosW-1:0]  kernel_row;
      logic [PosW-1:0]  kernel_col;
      logic [MeanW-1:0] mean_0;
      logic [MeanW-1:0] mean_1;
      logic [MeanW-1:0] mean_2;
      logic             window_done;
   } kernel_mean_type;

   typedef enum logic { ROW_CSR, ROW_PIXEL } plan_kind_type;

   typedef struct {
      plan_kind_type       kind;
      logic [CsrIdxW-1:0]  index;
      logic [CfgW-1:0]     data;
      pixel_type           pix;
      bit                  known;
      kernel_mean_type     want;
   } plan_row_type;

   logic clock;
   logic reset;

   wbap_req_if req_ch ();
   wbap_rsp_if rsp_ch ();
   wbap_csr_if csr_ch ();

   window_block_average_pool dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor copy of registers and accumulators
   logic [CfgW-1:0] side_reg;
   logic [CfgW-1:0] count_reg;
   logic            color_reg;
   logic [31:0]     sum_ch0 [SideBound];
   logic [31:0]     sum_ch1 [SideBound];
   logic [31:0]     sum_ch2 [SideBound];
   int unsigned     row_pos, col_pos, band_pos, kcol_pos;

   kernel_mean_type pending_means [$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;

   // coordination between sender, receiver and monitor
   bit              hold_request = 1'b0;
   bit              quiet_tail   = 1'b0;
   bit              req_gaps_on  = 1'b1;
   bit              rsp_gaps_on  = 1'b1;
   bit              drive_known  = 1'b0;
   kernel_mean_type drive_want   = '0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // zero acts as one, anything above the bound acts as the bound
   function automatic int unsigned effective_count(logic [CfgW-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > SideBound) return SideBound;
      return 32'(v);
   endfunction

   // accumulate one pixel, return 1 with the kernel mean when a kernel ends
   function automatic bit predict_kernel_mean(input pixel_type pix,
                                              output kernel_mean_type mean);
      int unsigned side, count, kc, area;
      bit          three, end_col, end_row, end_kcol, end_band, ended;
      side  = effective_count(side_reg);
      count = effective_count(count_reg);
      three = color_reg;
      kc    = (kcol_pos >= SideBound) ? SideBound - 1 : kcol_pos;
      ended = 1'b0;
      mean  = '0;

      sum_ch0[kc] += 32'(pix.ch0);
      if (three) begin
         sum_ch1[kc] += 32'(pix.ch1);
         sum_ch2[kc] += 32'(pix.ch2);
      end

      // counters at or past their last value count as at it
      end_col  = col_pos + 1 >= side;
      end_row  = row_pos + 1 >= side;
      end_kcol = kcol_pos + 1 >= count;
      end_band = band_pos + 1 >= count;

      if (end_col && end_row) begin
         area             = side * side;
         mean.kernel_row  = PosW'(band_pos);
         mean.kernel_col  = PosW'(kcol_pos);
         mean.mean_0      = MeanW'((sum_ch0[kc] << 8) / area);
         mean.mean_1      = three ? MeanW'((sum_ch1[kc] << 8) / area) : '0;
         mean.mean_2      = three ? MeanW'((sum_ch2[kc] << 8) / area) : '0;
         mean.window_done = end_kcol && end_band;
         sum_ch0[kc] = '0;
         sum_ch1[kc] = '0;
         sum_ch2[kc] = '0;
         ended = 1'b1;
      end

      // raster walk: column in kernel, kernel column, row in band, band
      if (!end_col) begin
         col_pos++;
      end else begin
         col_pos = 0;
         if (!end_kcol) begin
            kcol_pos++;
         end else begin
            kcol_pos = 0;
            if (!end_row) begin
               row_pos++;
            end else begin
               row_pos  = 0;
               band_pos = end_band ? 0 : band_pos + 1;
            end
         end
      end
      return ended;
   endfunction

   task automatic report_mismatch(bit had_want, kernel_mean_type want, kernel_mean_type got);
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
         if (had_want) begin
            $display("%0t mismatch: expected row %0d col %0d means %h %h %h done %b",
                     $time, want.kernel_row, want.kernel_col, want.mean_0, want.mean_1,
                     want.mean_2, want.window_done);
         end else begin
            $display("%0t mismatch: no result expected", $time);
         end
         $display("%0t          actual   row %0d col %0d means %h %h %h done %b",
                  $time, got.kernel_row, got.kernel_col, got.mean_0, got.mean_1,
                  got.mean_2, got.window_done);
      end
   endtask

   // monitor: check results, track register writes, predict accepted pixels
   always @(posedge clock) begin
      kernel_mean_type got, want, predicted;
      pixel_type       pix;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.kernel_row, rsp_ch.kernel_col, rsp_ch.mean_0, rsp_ch.mean_1,
                   rsp_ch.mean_2, rsp_ch.window_done};
            if (pending_means.size() == 0) begin
               report_mismatch(1'b0, '0, got);
            end else begin
               want = pending_means.pop_front();
               if (got.kernel_row !== want.kernel_row || got.kernel_col !== want.kernel_col ||
                   got.mean_0 !== want.mean_0 || got.mean_1 !== want.mean_1 ||
                   got.mean_2 !== want.mean_2 || got.window_done !== want.window_done) begin
                  report_mismatch(1'b1, want, got);
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_KERNEL_SIZE: side_reg  = csr_ch.data;
               CSR_NUM_KERNELS: count_reg = csr_ch.data;
               CSR_COLOR_MODE:  color_reg = csr_ch.data[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            pix = {req_ch.channel_0, req_ch.channel_1, req_ch.channel_2};
            if (predict_kernel_mean(pix, predicted) && !drive_known) begin
               pending_means.push_back(predicted);
            end
            if (drive_known) begin
               pending_means.push_back(drive_want);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("window_block_average_pool regression: fail");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ch.ready = 1'b0;
            repeat (RspHoldCycles) @(negedge clock);
            hold_request = 1'b0;
         end else if (rsp_gaps_on && !quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(0, IdleMax - 1)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   function automatic plan_row_type csr_row(logic [CsrIdxW-1:0] index, logic [CfgW-1:0] data);
      plan_row_type r;
      r.kind  = ROW_CSR;
      r.index = index;
      r.data  = data;
      r.pix   = '0;
      r.known = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic plan_row_type pixel_row(pixel_type pix, bit known,
                                              kernel_mean_type want);
      plan_row_type r;
      r.kind  = ROW_PIXEL;
      r.index = '0;
      r.data  = '0;
      r.pix   = pix;
      r.known = known;
      r.want  = want;
      return r;
   endfunction

   function automatic logic [PixW-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PixW'($urandom);
      endcase
   endfunction

   // one pixel transaction, with an optional gap ahead of it
   task automatic drive_pixel(pixel_type pix, bit known, kernel_mean_type want);
      if (req_gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, IdleMax)) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.channel_0 = pix.ch0;
      req_ch.channel_1 = pix.ch1;
      req_ch.channel_2 = pix.ch2;
      drive_known      = known;
      drive_want       = want;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // stop offering pixels until every result is in and the divider has settled
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(logic [CsrIdxW-1:0] index, logic [CfgW-1:0] data);
      wait_drained();
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data  = data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // stimulus
   initial begin
      plan_row_type    plan [$];
      kernel_mean_type none;
      pixel_type       pix;
      logic [CfgW-1:0] side_val, count_val;
      int              sent, phase, burst, pixels;

      none = '0;
      req_ch.valid     = 1'b0;
      req_ch.channel_0 = '0;
      req_ch.channel_1 = '0;
      req_ch.channel_2 = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;

      // predictor starts from the reset state
      side_reg  = KERNEL_SIZE_RESET;
      count_reg = NUM_KERNELS_RESET;
      color_reg = COLOR_MODE_RESET;
      foreach (sum_ch0[i]) begin
         sum_ch0[i] = '0;
         sum_ch1[i] = '0;
         sum_ch2[i] = '0;
      end
      row_pos  = 0;
      col_pos  = 0;
      band_pos = 0;
      kcol_pos = 0;

      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-pixel kernels: the mean is the sample shifted up by eight
      plan.push_back(csr_row(CSR_KERNEL_SIZE, 4'd1));
      plan.push_back(csr_row(CSR_NUM_KERNELS, 4'd1));
      plan.push_back(csr_row(CSR_COLOR_MODE, 4'd1));
      plan.push_back(pixel_row({8'hFF, 8'hFF, 8'hFF}, 1'b1,
                               {4'd0, 4'd0, 16'hFF00, 16'hFF00, 16'hFF00, 1'b1}));
      plan.push_back(pixel_row({8'h00, 8'h00, 8'h00}, 1'b1,
                               {4'd0, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1}));
      plan.push_back(pixel_row({8'hAA, 8'h55, 8'h01}, 1'b1,
                               {4'd0, 4'd0, 16'hAA00, 16'h5500, 16'h0100, 1'b1}));
      // gray mode through an out-of-width write, upper bits dropped
      plan.push_back(csr_row(CSR_COLOR_MODE, 4'hE));
      plan.push_back(pixel_row({8'hFF, 8'hFF, 8'hFF}, 1'b1,
                               {4'd0, 4'd0, 16'hFF00, 16'h0000, 16'h0000, 1'b1}));
      // zero sizes act as one
      plan.push_back(csr_row(CSR_KERNEL_SIZE, 4'd0));
      plan.push_back(csr_row(CSR_NUM_KERNELS, 4'd0));
      plan.push_back(csr_row(CSR_COLOR_MODE, 4'hF));
      plan.push_back(pixel_row({8'h80, 8'h7F, 8'hFF}, 1'b1,
                               {4'd0, 4'd0, 16'h8000, 16'h7F00, 16'hFF00, 1'b1}));
      // write to the unused index changes nothing
      plan.push_back(csr_row(CSR_SPARE, 4'h7));
      plan.push_back(pixel_row({8'h01, 8'h02, 8'h03}, 1'b1,
                               {4'd0, 4'd0, 16'h0100, 16'h0200, 16'h0300, 1'b1}));
      // one 3x3 kernel of mixed samples
      plan.push_back(csr_row(CSR_KERNEL_SIZE, 4'd3));
      plan.push_back(pixel_row({8'hFF, 8'h00, 8'h80}, 1'b0, none));
      plan.push_back(pixel_row({8'h00, 8'hFF, 8'h7F}, 1'b0, none));
      plan.push_back(pixel_row({8'hFF, 8'hFF, 8'h01}, 1'b0, none));
      plan.push_back(pixel_row({8'h12, 8'h34, 8'h56}, 1'b0, none));
      plan.push_back(pixel_row({8'h00, 8'h00, 8'hFE}, 1'b0, none));
      plan.push_back(pixel_row({8'hFF, 8'h80, 8'h00}, 1'b0, none));
      plan.push_back(pixel_row({8'h01, 8'hFE, 8'hFF}, 1'b0, none));
      plan.push_back(pixel_row({8'hC3, 8'h3C, 8'h5A}, 1'b0, none));
      plan.push_back(pixel_row({8'hFF, 8'hFF, 8'hFF}, 1'b0, none));
      // largest sizes, then shrink both mid-window
      plan.push_back(csr_row(CSR_KERNEL_SIZE, 4'd15));
      plan.push_back(csr_row(CSR_NUM_KERNELS, 4'd15));
      plan.push_back(pixel_row({8'hFF, 8'hFF, 8'hFF}, 1'b0, none));
      plan.push_back(pixel_row({8'hFF, 8'hFF, 8'hFF}, 1'b0, none));
      plan.push_back(pixel_row({8'hFF, 8'hFF, 8'hFF}, 1'b0, none));
      plan.push_back(csr_row(CSR_KERNEL_SIZE, 4'd1));
      plan.push_back(pixel_row({8'hFF, 8'h10, 8'h00}, 1'b0, none));
      plan.push_back(pixel_row({8'h20, 8'hFF, 8'h40}, 1'b0, none));
      plan.push_back(pixel_row({8'h9A, 8'hBC, 8'hDE}, 1'b0, none));
      plan.push_back(csr_row(CSR_NUM_KERNELS, 4'd2));
      plan.push_back(pixel_row({8'h77, 8'h88, 8'h99}, 1'b0, none));
      plan.push_back(pixel_row({8'hFE, 8'h01, 8'h7E}, 1'b0, none));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_register(plan[i].index, plan[i].data);
         end else begin
            drive_pixel(plan[i].pix, plan[i].known, plan[i].want);
         end
      end
      drive_known = 1'b0;

      // random phases, each under its own register setting
      sent  = 0;
      phase = 0;
      while (sent < RandomItems) begin
         case ($urandom_range(0, 15))
            0: begin side_val = 4'd15; count_val = 4'd1;  end
            1: begin side_val = 4'd1;  count_val = 4'd15; end
            2: begin side_val = 4'd15; count_val = 4'd15; end
            3: begin side_val = 4'd0;  count_val = CfgW'($urandom_range(0, 3)); end
            4: begin side_val = CfgW'($urandom_range(1, 3)); count_val = 4'd0; end
            default: begin
               side_val  = CfgW'($urandom_range(1, 5));
               count_val = CfgW'($urandom_range(1, 5));
            end
         endcase
         // every pixel ends a kernel here, so a stalled receiver fills the block
         if (phase == HoldPhase) begin
            side_val  = 4'd1;
            count_val = 4'd3;
         end
         write_register(CSR_KERNEL_SIZE, side_val);
         write_register(CSR_NUM_KERNELS, count_val);
         write_register(CSR_COLOR_MODE, CfgW'($urandom));
         if ($urandom_range(0, 9) == 0) begin
            write_register(CSR_SPARE, CfgW'($urandom));
         end

         pixels = effective_count(side_val) * effective_count(count_val);
         pixels = pixels * pixels;
         req_gaps_on = $urandom_range(0, 2) != 0;
         rsp_gaps_on = $urandom_range(0, 2) != 0;
         if (phase == HoldPhase) begin
            burst        = HoldBurstItems;
            req_gaps_on  = 1'b0;
            hold_request = 1'b1;
         end else if (pixels <= 225 && $urandom_range(0, 1) == 1) begin
            burst = pixels;
         end else begin
            burst = $urandom_range(1, 60);
         end

         for (int k = 0; k < burst; k++) begin
            // now and then let every outstanding kernel come back first
            if ($urandom_range(0, 199) == 0) begin
               wait_drained();
            end
            pix = {random_sample(), random_sample(), random_sample()};
            drive_pixel(pix, 1'b0, none);
            sent++;
            if (sent >= RandomItems - QuietTailItems) begin
               quiet_tail = 1'b1;
            end
         end
         phase++;
      end

      // let the last kernels drain
      req_ch.valid = 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (2 * LatencyCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_means.size() == 0) begin
         $display("window_block_average_pool regression: pass");
      end else begin
         $display("window_block_average_pool regression: fail");
      end
      $finish;
   end

endmodule
